// ===== hw/rtl/knc_pkg.sv =====
// Shared types and constants for the k-nearest candidate list block.
`timescale 1ns / 1ps
package knc_pkg;

  localparam int unsigned NodeBits  = 10;
  localparam int unsigned RankBits  = 4;
  localparam int unsigned KBits     = 5;
  localparam int unsigned NodesBits = 11;
  localparam int unsigned NodesMax  = 1024;
  localparam int unsigned IdxBits   = 7;

  typedef enum logic {
    REG_REQUESTED_COUNT = 1'b0,
    REG_NODE_COUNT      = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic insert;
    logic clear;
  } sort_ctl_t;

endpackage

// ===== hw/rtl/knc_sort_cell.sv =====
// One cell of the sorted insertion chain.
`timescale 1ns / 1ps
module knc_sort_cell #(
  parameter int unsigned COST_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  knc_pkg::sort_ctl_t                ctl_i,
  input  logic                              en_i,
  input  logic signed [COST_BITS-1:0]       new_cost_i,
  input  logic [knc_pkg::NodeBits-1:0]      new_node_i,
  input  logic signed [COST_BITS-1:0]       prev_cost_i,
  input  logic [knc_pkg::NodeBits-1:0]      prev_node_i,
  input  logic                              prev_valid_i,
  input  logic                              prev_before_i,
  output logic signed [COST_BITS-1:0]       cost_o,
  output logic [knc_pkg::NodeBits-1:0]      node_o,
  output logic                              valid_o,
  output logic                              before_o,
  output logic signed [COST_BITS-1:0]       upd_cost_o,
  output logic [knc_pkg::NodeBits-1:0]      upd_node_o,
  output logic                              upd_valid_o
);

  logic signed [COST_BITS-1:0]  cost_q, cost_d;
  logic [knc_pkg::NodeBits-1:0] node_q, node_d;
  logic                         valid_q, valid_d;
  logic                         eff_valid;
  logic                         ahead;

  assign eff_valid = valid_q & en_i;
  assign ahead     = eff_valid & ((cost_q < new_cost_i) ||
                                  ((cost_q == new_cost_i) && (node_q < new_node_i)));

  always_comb begin
    cost_d      = cost_q;
    node_d      = node_q;
    upd_valid_o = eff_valid;
    if (ctl_i.insert && en_i && !ahead) begin
      if (prev_before_i) begin
        cost_d      = new_cost_i;
        node_d      = new_node_i;
        upd_valid_o = 1'b1;
      end else begin
        cost_d      = prev_cost_i;
        node_d      = prev_node_i;
        upd_valid_o = prev_valid_i;
      end
    end
    valid_d = upd_valid_o & ~ctl_i.clear;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cost_q <= cost_d;
    node_q <= node_d;
  end

  assign cost_o     = cost_q;
  assign node_o     = node_q;
  assign valid_o    = eff_valid;
  assign before_o   = ahead;
  assign upd_cost_o = cost_d;
  assign upd_node_o = node_d;

endmodule

// ===== hw/rtl/knc_drain_cell.sv =====
// One cell of the output shift chain that drains a finished list.
`timescale 1ns / 1ps
module knc_drain_cell #(
  parameter int unsigned COST_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic                              shift_i,
  input  logic signed [COST_BITS-1:0]       load_cost_i,
  input  logic [knc_pkg::NodeBits-1:0]      load_node_i,
  input  logic                              load_valid_i,
  input  logic signed [COST_BITS-1:0]       next_cost_i,
  input  logic [knc_pkg::NodeBits-1:0]      next_node_i,
  input  logic                              next_valid_i,
  output logic signed [COST_BITS-1:0]       cost_o,
  output logic [knc_pkg::NodeBits-1:0]      node_o,
  output logic                              valid_o
);

  logic signed [COST_BITS-1:0]  cost_q, cost_d;
  logic [knc_pkg::NodeBits-1:0] node_q, node_d;
  logic                         valid_q, valid_d;

  always_comb begin
    cost_d  = cost_q;
    node_d  = node_q;
    valid_d = valid_q;
    priority if (load_i) begin
      cost_d  = load_cost_i;
      node_d  = load_node_i;
      valid_d = load_valid_i;
    end else if (shift_i) begin
      cost_d  = next_cost_i;
      node_d  = next_node_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cost_q <= cost_d;
    node_q <= node_d;
  end

  assign cost_o  = cost_q;
  assign node_o  = node_q;
  assign valid_o = valid_q;

endmodule

// ===== hw/rtl/k_nearest_candidate_lists.sv =====
// Top level: k-nearest candidate list builder with insertion chain and output drain.
`timescale 1ns / 1ps
// Takes one edge cost per cycle, one row of the cost matrix per source node, and keeps the
// k cheapest neighbors of the row (ties to the lower index, self pair skipped) in a chain of
// K_MAX sorting cells that compare every cell with the new word in the same cycle. At the row
// end the finished list moves at once into a second chain of cells that shifts it out, one
// candidate word per cycle in ascending order, while the next row already streams in. The
// input thus runs at one word per cycle; a row-end word waits only while the previous list is
// still draining its kept candidates (at most K_MAX), which output back-pressure can hold up.
// Write the configuration registers only while the block is idle.
module k_nearest_candidate_lists #(
  parameter int unsigned K_MAX     = 16,
  parameter int unsigned COST_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [10:0]                cfg_data_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // cost, neighbor
  input  logic [((COST_BITS+10+7)/8)*8-1:0] s_axis_tdata,
  // row_end
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // row_node, rank, candidate, cost
  output logic [((COST_BITS+24+7)/8)*8-1:0] m_axis_tdata,
  // last
  output logic                       m_axis_tlast
);

  localparam int unsigned NB      = knc_pkg::NodeBits;
  localparam int unsigned RW      = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int unsigned InW     = ((COST_BITS + 10 + 7) / 8) * 8;
  localparam int unsigned OutW    = ((COST_BITS + 24 + 7) / 8) * 8;
  localparam int unsigned NodeCap = (knc_pkg::NodesMax > 2047) ? 2047 : knc_pkg::NodesMax;

  logic [knc_pkg::KBits-1:0]     k_q;
  logic [knc_pkg::NodesBits-1:0] nodes_q;
  logic [NB-1:0]                 row_q;
  logic [NB-1:0]                 drow_q;
  logic [RW-1:0]                 rank_q;

  logic signed [COST_BITS-1:0]   new_cost;
  logic [NB-1:0]                 new_node;
  logic                          in_acc, out_acc, drain_free;
  knc_pkg::sort_ctl_t            ctl;

  logic signed [COST_BITS-1:0]   s_cost [K_MAX+1];
  logic [NB-1:0]                 s_node [K_MAX+1];
  logic                          s_valid [K_MAX+1];
  logic                          s_before [K_MAX+1];
  logic signed [COST_BITS-1:0]   u_cost [K_MAX];
  logic [NB-1:0]                 u_node [K_MAX];
  logic                          u_valid [K_MAX];
  logic                          cell_en [K_MAX];

  logic signed [COST_BITS-1:0]   d_cost [K_MAX+1];
  logic [NB-1:0]                 d_node [K_MAX+1];
  logic                          d_valid [K_MAX+1];

  logic [knc_pkg::NodesBits-1:0] eff_nodes;
  logic [knc_pkg::NodesBits-1:0] row_inc;
  logic [RW+3:0]                 rank_ext;
  logic [InW-1:0]                in_word;

  assign in_word  = s_axis_tdata;
  assign new_cost = in_word[COST_BITS-1:0];
  assign new_node = in_word[COST_BITS +: NB];

  assign drain_free    = ~d_valid[0] | (m_axis_tready & ~d_valid[1]);
  assign s_axis_tready = ~s_axis_tlast | drain_free;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_acc       = d_valid[0] & m_axis_tready;

  assign ctl.insert = in_acc & (new_node != row_q);
  assign ctl.clear  = in_acc & s_axis_tlast;

  // chain head: the new word always ranks after an empty predecessor
  assign s_cost[0]   = new_cost;
  assign s_node[0]   = new_node;
  assign s_valid[0]  = 1'b0;
  assign s_before[0] = 1'b1;

  assign d_cost[K_MAX]  = '0;
  assign d_node[K_MAX]  = '0;
  assign d_valid[K_MAX] = 1'b0;

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    assign cell_en[i] = ({2'b00, k_q} > knc_pkg::IdxBits'(i));

    knc_sort_cell #(
      .COST_BITS(COST_BITS)
    ) u_sort (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .en_i         (cell_en[i]),
      .new_cost_i   (new_cost),
      .new_node_i   (new_node),
      .prev_cost_i  (s_cost[i]),
      .prev_node_i  (s_node[i]),
      .prev_valid_i (s_valid[i]),
      .prev_before_i(s_before[i]),
      .cost_o       (s_cost[i+1]),
      .node_o       (s_node[i+1]),
      .valid_o      (s_valid[i+1]),
      .before_o     (s_before[i+1]),
      .upd_cost_o   (u_cost[i]),
      .upd_node_o   (u_node[i]),
      .upd_valid_o  (u_valid[i])
    );

    knc_drain_cell #(
      .COST_BITS(COST_BITS)
    ) u_drain (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (ctl.clear),
      .shift_i     (out_acc),
      .load_cost_i (u_cost[i]),
      .load_node_i (u_node[i]),
      .load_valid_i(u_valid[i]),
      .next_cost_i (d_cost[i+1]),
      .next_node_i (d_node[i+1]),
      .next_valid_i(d_valid[i+1]),
      .cost_o      (d_cost[i]),
      .node_o      (d_node[i]),
      .valid_o     (d_valid[i])
    );
  end

  always_comb begin
    eff_nodes = nodes_q;
    if (nodes_q == '0) begin
      eff_nodes = knc_pkg::NodesBits'(1);
    end else if (nodes_q > knc_pkg::NodesBits'(NodeCap)) begin
      eff_nodes = knc_pkg::NodesBits'(NodeCap);
    end
  end

  assign row_inc = {1'b0, row_q} + knc_pkg::NodesBits'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= knc_pkg::KBits'(8);
      nodes_q <= knc_pkg::NodesBits'(1024);
      row_q   <= '0;
      drow_q  <= '0;
      rank_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (knc_pkg::cfg_reg_e'(cfg_idx_i))
          knc_pkg::REG_REQUESTED_COUNT: k_q     <= cfg_data_i[knc_pkg::KBits-1:0];
          knc_pkg::REG_NODE_COUNT:      nodes_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctl.clear) begin
        drow_q <= row_q;
        rank_q <= '0;
        row_q  <= (row_inc >= eff_nodes) ? '0 : row_inc[NB-1:0];
      end else if (out_acc) begin
        rank_q <= rank_q + RW'(1);
      end
    end
  end

  assign rank_ext = {4'b0000, rank_q};

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[NB-1:0]                          = drow_q;
    m_axis_tdata[NB +: knc_pkg::RankBits]         = rank_ext[3:0];
    m_axis_tdata[NB+knc_pkg::RankBits +: NB]      = d_node[0];
    m_axis_tdata[2*NB+knc_pkg::RankBits +: COST_BITS] = d_cost[0];
  end

  assign m_axis_tvalid = d_valid[0];
  assign m_axis_tlast  = d_valid[0] & ~d_valid[1];

endmodule

// ===== test/tb_k_nearest_candidate_lists.sv =====
// Testbench for the k-nearest candidate list block: directed table, random rows, predictor check.
`timescale 1ns / 1ps
module tb_k_nearest_candidate_lists;

  localparam int KMax       = 16;
  localparam int RandItems  = 480;
  localparam int SettleCyc  = 40;

  typedef struct packed {
    logic [9:0]         row_node;
    logic [3:0]         rank;
    logic [9:0]         candidate;
    logic signed [31:0] cost;
    logic               last;
  } cand_t;

  typedef struct {
    bit                 is_cfg;
    knc_pkg::cfg_reg_e  reg_sel;
    int unsigned        value;
    logic signed [31:0] cost;
    logic [9:0]         nb;
    bit                 row_end;
    int                 exp_n;
    logic [9:0]         exp_cand;
    logic signed [31:0] exp_cost;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [10:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // cost, neighbor
  logic [47:0] s_axis_tdata = '0;
  // row_end
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // row_node, rank, candidate, cost
  logic [55:0] m_axis_tdata;
  // last
  logic        m_axis_tlast;

  k_nearest_candidate_lists dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [4:0]         k_reg = 5'd8;
  logic [10:0]        nodes_reg = 11'd1024;
  logic signed [31:0] chain_cost [KMax];
  logic [9:0]         chain_node [KMax];
  int                 chain_len = 0;
  logic [9:0]         cur_row = '0;

  cand_t pending_cands[$];
  int    err_count = 0;
  int    words_sent = 0;
  int    rows_done = 0;
  int    cands_checked = 0;
  int    reg_writes = 0;
  int    burst_left = 0;
  bit    gaps_on = 1'b1;
  logic [8:0] stall_tick = '0;

  stim_row_t dir_tab[23] = '{
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sh7FFFFFFF, 10'd5, 0, -1, 10'd0, 32'sd0},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sh80000000, 10'd1023, 0, -1, 10'd0, 32'sd0},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sd0, 10'd0, 0, -1, 10'd0, 32'sd0},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, -32'sd1, 10'd3, 0, -1, 10'd0, 32'sd0},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, -32'sd1, 10'd2, 1, 4, 10'd1023, 32'sh80000000},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sd5, 10'd1, 1, 0, 10'd0, 32'sd0},
    '{1, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sd0, 10'd0, 0, -1, 10'd0, 32'sd0},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sd7, 10'd9, 1, 0, 10'd0, 32'sd0},
    '{1, knc_pkg::REG_REQUESTED_COUNT, 31, 32'sd0, 10'd0, 0, -1, 10'd0, 32'sd0},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sd4, 10'd9, 0, -1, 10'd0, 32'sd0},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sd4, 10'd7, 0, -1, 10'd0, 32'sd0},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sd4, 10'd7, 0, -1, 10'd0, 32'sd0},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sd4, 10'd1020, 1, 4, 10'd7, 32'sd4},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sd10, 10'd6, 0, -1, 10'd0, 32'sd0},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sd3, 10'd8, 0, -1, 10'd0, 32'sd0},
    '{1, knc_pkg::REG_REQUESTED_COUNT, 1, 32'sd0, 10'd0, 0, -1, 10'd0, 32'sd0},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sd9, 10'd11, 1, 1, 10'd8, 32'sd3},
    '{1, knc_pkg::REG_NODE_COUNT, 0, 32'sd0, 10'd0, 0, -1, 10'd0, 32'sd0},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sd1, 10'd2, 1, 1, 10'd2, 32'sd1},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sd1, 10'd0, 1, 0, 10'd0, 32'sd0},
    '{1, knc_pkg::REG_NODE_COUNT, 2047, 32'sd0, 10'd0, 0, -1, 10'd0, 32'sd0},
    '{1, knc_pkg::REG_REQUESTED_COUNT, 16, 32'sd0, 10'd0, 0, -1, 10'd0, 32'sd0},
    '{0, knc_pkg::REG_REQUESTED_COUNT, 0, 32'sd2, 10'd1023, 1, 1, 10'd1023, 32'sd2}
  };

  function automatic bit ranks_ahead(input logic signed [31:0] ca, input logic [9:0] na,
                                     input logic signed [31:0] cb, input logic [9:0] nb);
    if (ca != cb) return ca < cb;
    return na < nb;
  endfunction

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", what, want, got);
      err_count++;
    end
  endtask

  // insert one cost word into the chain; emit the list on row end
  task automatic rank_word(input logic signed [31:0] c, input logic [9:0] nb,
                           input logic row_end, output int n_out);
    int    k;
    int    pos;
    int    top;
    int    nodes_eff;
    int    nxt;
    cand_t item;
    k = (k_reg > KMax) ? KMax : int'(k_reg);
    if (chain_len > k) chain_len = k;
    if (nb != cur_row && k > 0) begin
      pos = 0;
      while (pos < chain_len && ranks_ahead(chain_cost[pos], chain_node[pos], c, nb)) pos++;
      if (pos < k) begin
        top = (chain_len < k) ? chain_len : k - 1;
        for (int i = top; i > pos; i--) begin
          chain_cost[i] = chain_cost[i-1];
          chain_node[i] = chain_node[i-1];
        end
        chain_cost[pos] = c;
        chain_node[pos] = nb;
        if (chain_len < k) chain_len++;
      end
    end
    n_out = 0;
    if (row_end) begin
      for (int i = 0; i < chain_len; i++) begin
        item.row_node  = cur_row;
        item.rank      = i[3:0];
        item.candidate = chain_node[i];
        item.cost      = chain_cost[i];
        item.last      = (i + 1 == chain_len);
        pending_cands.insert(pending_cands.size(), item);
      end
      n_out = chain_len;
      chain_len = 0;
      nodes_eff = (nodes_reg == 0) ? 1 :
                  ((nodes_reg > knc_pkg::NodesMax) ? knc_pkg::NodesMax : int'(nodes_reg));
      nxt = int'(cur_row) + 1;
      if (nxt >= nodes_eff) cur_row = '0;
      else cur_row = nxt[9:0];
      rows_done++;
    end
  endtask

  task automatic send_word(input logic signed [31:0] c, input logic [9:0] nb,
                           input logic row_end, output int n_out);
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, nb, c};
    s_axis_tlast  <= row_end;
    do @(posedge clk_i); while (!s_axis_tready);
    rank_word(c, nb, row_end, n_out);
    words_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  // hold the input until every candidate word has drained
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_cands.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input knc_pkg::cfg_reg_e sel, input int unsigned val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val[10:0];
    @(posedge clk_i);
    if (sel == knc_pkg::REG_REQUESTED_COUNT) k_reg = val[4:0];
    else nodes_reg = val[10:0];
    reg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_cost();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return int'($urandom_range(0, 16)) - 8;
    if (sel < 85) return $urandom();
    case ($urandom_range(0, 3))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic logic [9:0] pick_neighbor();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return cur_row;
    if (sel < 55) return 10'($urandom_range(0, 15));
    return 10'($urandom_range(0, 1023));
  endfunction

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[8:7])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready <= (stall_tick[1:0] == 2'd0);
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  cand_t want;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_cands.size() == 0) begin
        $error("candidate word with none expected: %h last %b", m_axis_tdata, m_axis_tlast);
        err_count++;
      end else begin
        want = pending_cands.pop_front();
        check_field("row_node", want.row_node, m_axis_tdata[9:0]);
        check_field("rank", want.rank, m_axis_tdata[13:10]);
        check_field("candidate", want.candidate, m_axis_tdata[23:14]);
        check_field("cost", want.cost, $signed(m_axis_tdata[55:24]));
        check_field("last", want.last, m_axis_tlast);
        cands_checked++;
      end
    end
  end

  initial begin
    int n_out;
    int phase;
    int k_pick;
    int n_pick;
    int sel;
    int rows;
    int len;
    int dir_words;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_idle();
        write_reg(dir_tab[i].reg_sel, dir_tab[i].value);
      end else begin
        send_word(dir_tab[i].cost, dir_tab[i].nb, dir_tab[i].row_end, n_out);
        if (dir_tab[i].exp_n >= 0) begin
          check_field("directed list length", dir_tab[i].exp_n, n_out);
          if (dir_tab[i].exp_n > 0 && n_out > 0) begin
            check_field("directed candidate", dir_tab[i].exp_cand,
                        pending_cands[pending_cands.size() - n_out].candidate);
            check_field("directed cost", dir_tab[i].exp_cost,
                        pending_cands[pending_cands.size() - n_out].cost);
          end
        end
      end
    end
    dir_words = words_sent;

    phase = 0;
    while (words_sent < dir_words + RandItems) begin
      sel = $urandom_range(0, 99);
      if (phase == 0) k_pick = KMax;
      else if (phase == 1) k_pick = 0;
      else if (sel < 20) k_pick = KMax;
      else if (sel < 30) k_pick = 0;
      else if (sel < 40) k_pick = $urandom_range(17, 31);
      else k_pick = $urandom_range(1, 15);
      sel = $urandom_range(0, 99);
      if (phase == 0) n_pick = 1;
      else if (phase == 1) n_pick = 1024;
      else if (phase == 2) n_pick = 0;
      else if (sel < 70) n_pick = $urandom_range(1, 6);
      else if (sel < 85) n_pick = $urandom_range(7, 1024);
      else if (sel < 95) n_pick = $urandom_range(1025, 2047);
      else n_pick = 0;
      wait_idle();
      write_reg(knc_pkg::REG_REQUESTED_COUNT, k_pick);
      write_reg(knc_pkg::REG_NODE_COUNT, n_pick);
      gaps_on = ($urandom_range(0, 3) != 0);
      rows = $urandom_range(2, 6);
      for (int r = 0; r < rows; r++) begin
        sel = $urandom_range(0, 99);
        if (sel < 30) len = $urandom_range(1, 3);
        else if (sel < 85) len = $urandom_range(4, 20);
        else len = $urandom_range(21, 40);
        for (int j = 0; j < len; j++) begin
          send_word(pick_cost(), pick_neighbor(), (j == len - 1), n_out);
        end
      end
      phase++;
    end

    wait_idle();
    $display("covered %0d cost words in %0d rows over %0d register settings;",
             words_sent, rows_done, reg_writes);
    $display("checked %0d candidate words against the predicted lists", cands_checked);
    if (err_count == 0) begin
      $display("tb_k_nearest_candidate_lists: done, clean");
    end else begin
      $display("tb_k_nearest_candidate_lists: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d candidate words outstanding", pending_cands.size());
    $display("tb_k_nearest_candidate_lists: done, errors");
    $finish;
  end

endmodule
